@@ hw/rtl/mrf_pkg.sv @@
// Shared types, constants and frame helpers for the Modbus RTU request framer.
package mrf_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes and widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_STATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_CODE   = 2'd3;

  localparam logic [7:0] WIDE_STATION_RST = 8'd1;
  localparam logic [7:0] READ_CODE_RST    = 8'd3;
  localparam logic [7:0] SINGLE_CODE_RST  = 8'd6;
  localparam logic [7:0] MULTI_CODE_RST   = 8'd16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    KIND_SHORT,
    KIND_MULTI_NARROW,
    KIND_MULTI_WIDE
  } kind_t;

  typedef struct packed {
    logic [7:0]  station;
    logic [7:0]  code;
    logic [15:0] addr;
    logic [31:0] value;
    kind_t       kind;
  } req_desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BODY,
    BK_CRC_LO,
    BK_CRC_HI
  } back_state_t;

  // One byte through the reflected CRC-16/MODBUS register.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Number of body bytes before the CRC.
  function automatic logic [3:0] body_len(input kind_t kind);
    logic [3:0] n;
    unique case (kind)
      KIND_SHORT:        n = 4'd6;
      KIND_MULTI_NARROW: n = 4'd9;
      KIND_MULTI_WIDE:   n = 4'd11;
      default:           n = 4'd6;
    endcase
    return n;
  endfunction

  // Body byte at a given position of the frame.
  function automatic logic [7:0] body_byte(input req_desc_t d, input logic [3:0] pos);
    logic [7:0] b;
    logic       short_f;
    logic       wide_f;
    short_f = (d.kind == KIND_SHORT);
    wide_f  = (d.kind == KIND_MULTI_WIDE);
    case (pos)
      4'd0:    b = d.station;
      4'd1:    b = d.code;
      4'd2:    b = d.addr[15:8];
      4'd3:    b = d.addr[7:0];
      4'd4:    b = short_f ? d.value[15:8] : 8'h00;
      4'd5:    b = short_f ? d.value[7:0] : (wide_f ? 8'd2 : 8'd1);
      4'd6:    b = wide_f ? 8'd4 : 8'd2;
      4'd7:    b = wide_f ? d.value[31:24] : d.value[15:8];
      4'd8:    b = wide_f ? d.value[23:16] : d.value[7:0];
      4'd9:    b = d.value[15:8];
      4'd10:   b = d.value[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/mrf_front.sv @@
// Front end: configuration registers, request classification and queue push.
module mrf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             push_i,
  input  logic [7:0]                       station_i,
  input  logic [7:0]                       code_i,
  input  logic [15:0]                      addr_i,
  input  logic [31:0]                      value_i,
  input  mrf_pkg::queue_stat_t             q_stat_i,
  output logic                             q_push_o,
  output mrf_pkg::req_desc_t               q_desc_o
);

  logic [7:0] wide_station_r;
  logic [7:0] read_code_r;
  logic [7:0] single_code_r;
  logic [7:0] multi_code_r;

  logic accept;
  logic short_hit;
  logic multi_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_station_r <= mrf_pkg::WIDE_STATION_RST;
      read_code_r    <= mrf_pkg::READ_CODE_RST;
      single_code_r  <= mrf_pkg::SINGLE_CODE_RST;
      multi_code_r   <= mrf_pkg::MULTI_CODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mrf_pkg::CFG_WIDE_STATION: wide_station_r <= cfg_wdata;
        mrf_pkg::CFG_READ_CODE:    read_code_r    <= cfg_wdata;
        mrf_pkg::CFG_SINGLE_CODE:  single_code_r  <= cfg_wdata;
        mrf_pkg::CFG_MULTI_CODE:   multi_code_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Read and single write share a layout and win over multiple write.
  always_comb begin
    accept    = push_i && !q_stat_i.full;
    short_hit = (code_i == read_code_r) || (code_i == single_code_r);
    multi_hit = (code_i == multi_code_r);

    q_desc_o.station = station_i;
    q_desc_o.code    = code_i;
    q_desc_o.addr    = addr_i;
    q_desc_o.value   = value_i;
    priority if (short_hit) begin
      q_desc_o.kind = mrf_pkg::KIND_SHORT;
    end else if (station_i == wide_station_r) begin
      q_desc_o.kind = mrf_pkg::KIND_MULTI_WIDE;
    end else begin
      q_desc_o.kind = mrf_pkg::KIND_MULTI_NARROW;
    end

    // Unknown codes are taken and silently dropped.
    q_push_o = accept && (short_hit || multi_hit);
  end

endmodule

@@ hw/rtl/mrf_queue.sv @@
// Short request queue between the front end and the frame sequencer.
module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_i,
  input  mrf_pkg::req_desc_t   wr_data_i,
  input  logic                 rd_i,
  output mrf_pkg::req_desc_t   rd_data_o,
  output mrf_pkg::queue_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrf_pkg::req_desc_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_i) begin
      mem_r[wr_ptr_r] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_i) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr_i && !rd_i) begin
        count_r <= count_r + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign rd_data_o    = mem_r[rd_ptr_r];
  assign stat_o.empty = (count_r == '0);
  assign stat_o.full  = (count_r == CW'(DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_i |-> !stat_o.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_i |-> !stat_o.empty)
    else $error("queue read while empty");

endmodule

@@ hw/rtl/mrf_back.sv @@
// Frame sequencer: walks one request's body, folds it into the CRC, then sends the CRC.
module mrf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrf_pkg::queue_stat_t q_stat_i,
  input  mrf_pkg::req_desc_t   q_desc_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           frame_byte_o,
  output logic                 last_byte_o
);

  mrf_pkg::back_state_t state_r, state_nxt;
  mrf_pkg::req_desc_t   desc_r;
  logic [3:0]           pos_r;
  logic [15:0]          crc_r;
  logic                 out_vld_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic       advance;
  logic       load;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       body_end;

  assign advance  = !out_vld_r || pop_i;
  assign body_end = (pos_r == (mrf_pkg::body_len(desc_r.kind) - 4'd1));

  always_comb begin
    load      = 1'b0;
    emit      = 1'b0;
    emit_byte = mrf_pkg::body_byte(desc_r, pos_r);
    emit_last = 1'b0;
    unique case (state_r)
      mrf_pkg::BK_IDLE: begin
        load = !q_stat_i.empty;
      end
      mrf_pkg::BK_BODY: begin
        emit = advance;
      end
      mrf_pkg::BK_CRC_LO: begin
        emit      = advance;
        emit_byte = crc_r[7:0];
      end
      mrf_pkg::BK_CRC_HI: begin
        emit      = advance;
        emit_byte = crc_r[15:8];
        emit_last = 1'b1;
        load      = advance && !q_stat_i.empty;
      end
      default: ;
    endcase
  end

  assign q_pop_o = load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrf_pkg::BK_IDLE: begin
        if (load) state_nxt = mrf_pkg::BK_BODY;
      end
      mrf_pkg::BK_BODY: begin
        if (advance && body_end) state_nxt = mrf_pkg::BK_CRC_LO;
      end
      mrf_pkg::BK_CRC_LO: begin
        if (advance) state_nxt = mrf_pkg::BK_CRC_HI;
      end
      mrf_pkg::BK_CRC_HI: begin
        if (advance) state_nxt = load ? mrf_pkg::BK_BODY : mrf_pkg::BK_IDLE;
      end
      default: state_nxt = mrf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mrf_pkg::BK_IDLE;
      pos_r     <= '0;
      crc_r     <= mrf_pkg::CRC_INIT;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        pos_r <= '0;
        crc_r <= mrf_pkg::CRC_INIT;
      end else if (state_r == mrf_pkg::BK_BODY && advance) begin
        pos_r <= pos_r + 4'd1;
        crc_r <= mrf_pkg::crc_feed(crc_r, emit_byte);
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (pop_i) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= q_desc_i;
    end
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign empty_o      = !out_vld_r;
  assign frame_byte_o = out_byte_r;
  assign last_byte_o  = out_last_r;

  a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrf_pkg::BK_BODY) |-> (pos_r < mrf_pkg::body_len(desc_r.kind)))
    else $error("body position ran past the frame body");

  a_crc_follows_body: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrf_pkg::BK_CRC_LO) |->
      ($past(state_r) == mrf_pkg::BK_BODY || $past(state_r) == mrf_pkg::BK_CRC_LO))
    else $error("CRC sent without a preceding body");

endmodule

@@ hw/rtl/modbus_rtu_request_framer_unit.sv @@
// Top level of the Modbus RTU request framer: front end, request queue and frame sequencer.
//
// Each transfer on the input side is one Modbus RTU master request (station, function
// code, register address, value); the block turns it into the request frame and hands
// the frame out one byte per transfer on the result side, with out_last_byte set on the
// high CRC byte. Read and write-single requests give 8 bytes, a write-multiple request
// gives 11 bytes, or 13 bytes with a 32-bit value when its station equals the configured
// wide-write station; a function code that matches no configured code is taken and
// produces nothing. The CRC is CRC-16/MODBUS, sent low byte first. The frame sequencer
// emits one byte per cycle while the consumer takes each byte, and a request that finds it
// idle is first loaded in the idle state; the sequencer's byte walk is what sets the rate.
// A queue of QUEUE_DEPTH requests lets the front end keep taking transfers while a frame
// is still going out. A single registered output stage holds the current byte, and the
// sequencer stalls for as long as the consumer leaves that byte untaken. Configuration
// registers are written through the cfg_ port and must only be changed while the block
// is idle.
module modbus_rtu_request_framer_unit #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_station,
  input  logic [7:0]                     in_function_code,
  input  logic [15:0]                    in_register_address,
  input  logic [31:0]                    in_request_value,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_frame_byte,
  output logic                           out_last_byte
);

  mrf_pkg::queue_stat_t q_stat;
  mrf_pkg::req_desc_t   q_wr_desc;
  mrf_pkg::req_desc_t   q_rd_desc;
  logic                 q_push;
  logic                 q_pop;

  // The input side is full exactly when the request queue is full.
  assign full = q_stat.full;

  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push_i    (push),
    .station_i (in_station),
    .code_i    (in_function_code),
    .addr_i    (in_register_address),
    .value_i   (in_request_value),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_desc_o  (q_wr_desc)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (q_push),
    .wr_data_i (q_wr_desc),
    .rd_i      (q_pop),
    .rd_data_o (q_rd_desc),
    .stat_o    (q_stat)
  );

  mrf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat_i     (q_stat),
    .q_desc_i     (q_rd_desc),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .frame_byte_o (out_frame_byte),
    .last_byte_o  (out_last_byte)
  );

endmodule
